/* sv/blsl_pkg.sv */
// ----------------------------------------------------------------------------
// blsl_pkg
// types and constants shared by the bounded sequential list
// ----------------------------------------------------------------------------
`default_nettype none

package blsl_pkg;

	localparam int unsigned OP_W     = 3;
	localparam int unsigned POS_W    = 7;
	localparam int unsigned VAL_W    = 32;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned FOUND_W  = 6;
	localparam int unsigned COUNT_W  = 7;
	localparam int unsigned Q_DEPTH  = 2;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH   = 3'd0,
		OP_POP    = 3'd1,
		OP_INSERT = 3'd2,
		OP_ERASE  = 3'd3,
		OP_FIND   = 3'd4,
		OP_CLEAR  = 3'd5
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_BADPOS   = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	// decoded command class
	typedef enum logic [2:0] {
		K_PUSH,
		K_POP,
		K_INSERT,
		K_ERASE,
		K_FIND,
		K_CLEAR,
		K_NOP
	} kind_t;

	typedef struct packed {
		kind_t                    kind;
		logic [POS_W-1:0]         position;
		logic signed [VAL_W-1:0]  value;
	} cmd_t;

endpackage

`default_nettype wire

/* sv/blsl_ifs.sv */
// ----------------------------------------------------------------------------
// blsl interfaces
// request and response channels of the bounded sequential list
// ----------------------------------------------------------------------------
`default_nettype none

interface blsl_cmd_if;
	logic                                 valid;
	logic                                 ready;
	logic [blsl_pkg::OP_W-1:0]            operation;
	logic [blsl_pkg::POS_W-1:0]           position;
	logic signed [blsl_pkg::VAL_W-1:0]    value;

	modport source (output valid, output operation, output position, output value,
		input ready);
	modport sink (input valid, input operation, input position, input value,
		output ready);
endinterface

interface blsl_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic [blsl_pkg::STATUS_W-1:0]        status;
	logic [blsl_pkg::FOUND_W-1:0]         found_index;
	logic [blsl_pkg::COUNT_W-1:0]         count;

	modport source (output valid, output status, output found_index, output count,
		input ready);
	modport sink (input valid, input status, input found_index, input count,
		output ready);
endinterface

`default_nettype wire

/* sv/bounded_sequential_list.sv */
// ----------------------------------------------------------------------------
// bounded_sequential_list
// bounded ordered list of signed 32-bit entries with a live count
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake    payload
//   cmd      in   valid/ready  operation[2:0] position[6:0] value[31:0]
//   rsp      out  valid/ready  status[2:0] found_index[5:0] count[6:0]
//
// push, pop, clear, unused codes, every rejected request and insert at the end
// finish in the idle state of the back end; insert inside the list moves entries
// up from the last one to position, then writes the value; erase moves those above
// position down, find scans from entry 0: each walk step moves or compares one entry
// a request passes a front register and a two-entry queue before execution
// reset clears the count, state and response valid, the entry ram is not swept
// while a response waits for rsp.ready the front keeps taking requests until
// the queue and the front register are full
//
`default_nettype none

module bounded_sequential_list #(
	parameter int unsigned CAPACITY = 64
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	blsl_cmd_if.sink    cmd,
	blsl_rsp_if.source  rsp
);
	import blsl_pkg::*;

	// front to queue
	logic dec_valid;
	cmd_t dec_cmd;
	logic dec_ready;

	// queue to back
	logic q_valid;
	cmd_t q_cmd;
	logic q_pop;

	// decode operation codes into command classes
	blsl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.dec_valid (dec_valid),
		.dec_cmd   (dec_cmd),
		.dec_ready (dec_ready)
	);

	// decouples request intake from the ram walks
	blsl_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (dec_valid),
		.push_cmd   (dec_cmd),
		.push_ready (dec_ready),
		.pop_valid  (q_valid),
		.pop_cmd    (q_cmd),
		.pop_ready  (q_pop)
	);

	// executes commands, owns the entry ram, count and response register
	blsl_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_cmd   (q_cmd),
		.q_pop   (q_pop),
		.rsp     (rsp)
	);

endmodule

`default_nettype wire

/* sv/blsl_ram.sv */
// ----------------------------------------------------------------------------
// blsl_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module blsl_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [$clog2(DEPTH)-1:0]   waddr,
	input  wire logic [WIDTH-1:0]           wdata,
	input  wire logic [$clog2(DEPTH)-1:0]   raddr,
	output logic      [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* sv/blsl_front.sv */
// ----------------------------------------------------------------------------
// blsl_front
// accepts requests and decodes the operation into a command class
// ----------------------------------------------------------------------------
`default_nettype none

module blsl_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	blsl_cmd_if.sink             cmd,
	output logic                 dec_valid,
	output blsl_pkg::cmd_t       dec_cmd,
	input  wire logic            dec_ready
);
	import blsl_pkg::*;

	logic  valid_s1;
	cmd_t  cmd_s1;
	kind_t kind;

	always_comb begin
		unique case (cmd.operation)
			OP_PUSH:   kind = K_PUSH;
			OP_POP:    kind = K_POP;
			OP_INSERT: kind = K_INSERT;
			OP_ERASE:  kind = K_ERASE;
			OP_FIND:   kind = K_FIND;
			OP_CLEAR:  kind = K_CLEAR;
			default:   kind = K_NOP;
		endcase
	end

	assign cmd.ready = !valid_s1 || dec_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			cmd_s1.kind     <= kind;
			cmd_s1.position <= cmd.position;
			cmd_s1.value    <= cmd.value;
		end
	end

	assign dec_valid = valid_s1;
	assign dec_cmd   = cmd_s1;

endmodule

`default_nettype wire

/* sv/blsl_queue.sv */
// ----------------------------------------------------------------------------
// blsl_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module blsl_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push_valid,
	input  wire blsl_pkg::cmd_t  push_cmd,
	output logic                 push_ready,
	output logic                 pop_valid,
	output blsl_pkg::cmd_t       pop_cmd,
	input  wire logic            pop_ready
);
	import blsl_pkg::*;

	localparam int unsigned PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int unsigned CW = $clog2(Q_DEPTH + 1);

	cmd_t          slot_q [Q_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] fill_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (fill_q != CW'(Q_DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_cmd    = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

/* sv/blsl_back.sv */
// ----------------------------------------------------------------------------
// blsl_back
// executes list commands against the entry ram and holds the count
// ----------------------------------------------------------------------------
`default_nettype none

module blsl_back #(
	parameter int unsigned CAPACITY = 64
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_valid,
	input  wire blsl_pkg::cmd_t  q_cmd,
	output logic                 q_pop,
	blsl_rsp_if.source           rsp
);
	import blsl_pkg::*;

	localparam int unsigned AW  = $clog2(CAPACITY);
	localparam int unsigned CW  = $clog2(CAPACITY + 1);
	localparam int unsigned PXW = (CW > POS_W) ? CW : POS_W;
	localparam int unsigned FXW = (AW > FOUND_W) ? AW : FOUND_W;
	localparam int unsigned CXW = (CW > COUNT_W) ? CW : COUNT_W;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_UP   = 5'b00010,
		S_PUT  = 5'b00100,
		S_DOWN = 5'b01000,
		S_FIND = 5'b10000
	} state_t;

	state_t           state_q, state_d;
	logic [CW-1:0]    cnt_q, cnt_d;
	logic [AW-1:0]    addr_q, addr_d;
	logic [AW-1:0]    pos_q;
	logic [VAL_W-1:0] val_q;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [VAL_W-1:0] ram_wdata;
	logic [AW-1:0]    ram_raddr;
	logic [VAL_W-1:0] ram_rdata;

	logic             take;
	logic             load;
	status_t          ld_status;
	logic [AW-1:0]    ld_found;

	logic [PXW-1:0]   pos_ext;
	logic [PXW-1:0]   cnt_ext;
	logic [CW-1:0]    cnt_m1;
	logic [AW-1:0]    last;
	logic [AW-1:0]    pos_addr;
	logic [FXW-1:0]   found_ext;
	logic [CXW-1:0]   cnt_out_ext;

	logic                rsp_valid_q;
	logic [STATUS_W-1:0] rsp_status_q;
	logic [FOUND_W-1:0]  rsp_found_q;
	logic [COUNT_W-1:0]  rsp_count_q;

	assign pos_ext  = PXW'(q_cmd.position);
	assign cnt_ext  = PXW'(cnt_q);
	assign cnt_m1   = cnt_q - 1'b1;
	assign last     = cnt_m1[AW-1:0];
	assign pos_addr = pos_ext[AW-1:0];

	assign take  = (state_q == S_IDLE) && q_valid && (!rsp_valid_q || rsp.ready);
	assign q_pop = take;

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		addr_d    = addr_q;
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = ram_rdata;
		ram_raddr = addr_q;
		load      = 1'b0;
		ld_status = ST_OK;
		ld_found  = '0;

		unique case (state_q)
			S_IDLE: begin
				if (take) begin
					case (q_cmd.kind)
						K_PUSH: begin
							load = 1'b1;
							if (cnt_q >= CW'(CAPACITY)) begin
								ld_status = ST_FULL;
							end else begin
								ram_we    = 1'b1;
								ram_waddr = cnt_q[AW-1:0];
								ram_wdata = q_cmd.value;
								cnt_d     = cnt_q + 1'b1;
							end
						end
						K_POP: begin
							load = 1'b1;
							if (cnt_q == '0) begin
								ld_status = ST_EMPTY;
							end else begin
								cnt_d = cnt_m1;
							end
						end
						K_INSERT: begin
							if (cnt_q >= CW'(CAPACITY)) begin
								load      = 1'b1;
								ld_status = ST_FULL;
							end else if (pos_ext > cnt_ext) begin
								load      = 1'b1;
								ld_status = ST_BADPOS;
							end else if (pos_ext == cnt_ext) begin
								// append at the end, nothing to shift
								load      = 1'b1;
								ram_we    = 1'b1;
								ram_waddr = pos_addr;
								ram_wdata = q_cmd.value;
								cnt_d     = cnt_q + 1'b1;
							end else begin
								ram_raddr = last;
								addr_d    = last;
								state_d   = S_UP;
							end
						end
						K_ERASE: begin
							if (cnt_q == '0) begin
								load      = 1'b1;
								ld_status = ST_EMPTY;
							end else if (pos_ext >= cnt_ext) begin
								load      = 1'b1;
								ld_status = ST_BADPOS;
							end else if (pos_addr == last) begin
								// last entry, only the count moves
								load  = 1'b1;
								cnt_d = cnt_m1;
							end else begin
								ram_raddr = pos_addr + 1'b1;
								addr_d    = pos_addr + 1'b1;
								state_d   = S_DOWN;
							end
						end
						K_FIND: begin
							if (cnt_q == '0) begin
								load      = 1'b1;
								ld_status = ST_NOTFOUND;
							end else begin
								ram_raddr = '0;
								addr_d    = '0;
								state_d   = S_FIND;
							end
						end
						K_CLEAR: begin
							load  = 1'b1;
							cnt_d = '0;
						end
						default: begin
							load = 1'b1;
						end
					endcase
				end
			end
			S_UP: begin
				// move entry addr_q one place up, read the one below
				ram_we    = 1'b1;
				ram_waddr = addr_q + 1'b1;
				if (addr_q == pos_q) begin
					state_d = S_PUT;
				end else begin
					ram_raddr = addr_q - 1'b1;
					addr_d    = addr_q - 1'b1;
				end
			end
			S_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q;
				ram_wdata = val_q;
				cnt_d     = cnt_q + 1'b1;
				load      = 1'b1;
				state_d   = S_IDLE;
			end
			S_DOWN: begin
				// move entry addr_q one place down
				ram_we    = 1'b1;
				ram_waddr = addr_q - 1'b1;
				if (addr_q == last) begin
					cnt_d   = cnt_m1;
					load    = 1'b1;
					state_d = S_IDLE;
				end else begin
					ram_raddr = addr_q + 1'b1;
					addr_d    = addr_q + 1'b1;
				end
			end
			S_FIND: begin
				if (ram_rdata == val_q) begin
					load     = 1'b1;
					ld_found = addr_q;
					state_d  = S_IDLE;
				end else if (addr_q == last) begin
					load      = 1'b1;
					ld_status = ST_NOTFOUND;
					state_d   = S_IDLE;
				end else begin
					ram_raddr = addr_q + 1'b1;
					addr_d    = addr_q + 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign found_ext   = FXW'(ld_found);
	assign cnt_out_ext = CXW'(cnt_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_q <= addr_d;
		if (take) begin
			pos_q <= pos_addr;
			val_q <= q_cmd.value;
		end
		if (load) begin
			rsp_status_q <= ld_status;
			rsp_found_q  <= found_ext[FOUND_W-1:0];
			rsp_count_q  <= cnt_out_ext[COUNT_W-1:0];
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.found_index = rsp_found_q;
	assign rsp.count       = rsp_count_q;

	blsl_ram #(
		.WIDTH (VAL_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_busy_no_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !rsp_valid_q)
		else $error("response pending while a walk is running");

	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIND || state_q == S_DOWN || state_q == S_UP)
		|-> (CW'(addr_q) < cnt_q))
		else $error("walk address beyond live entries");

	a_walk_ends_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE && state_d == S_IDLE) |=> rsp_valid_q)
		else $error("walk finished without a response");
`endif

endmodule

`default_nettype wire
